// ----- rtl/wvm_pkg.sv -----
// ----------------------------------------------------------------------------
// wvm_pkg
// Types and constants shared by the wavetable voice mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wvm_pkg;

    localparam int SMP_W      = 16;
    localparam int MIX_W      = 20;
    localparam int SLOT_W     = 7;
    localparam int ADDR_IN_W  = 16;
    localparam int STEP_W     = 20;
    localparam int FRAC_W     = 16;
    localparam int CARRY_W    = STEP_W - FRAC_W + 1;
    localparam int PHASE_W    = 32;
    localparam int FRAMES_W   = 16;

    localparam int EMIT_BURST = 64;
    localparam int BURST_W    = 6;
    localparam logic [BURST_W-1:0] BURST_LAST = BURST_W'(EMIT_BURST - 1);

    localparam logic signed [MIX_W-1:0] MIX_MAX = 20'sh7FFFF;
    localparam logic signed [MIX_W-1:0] MIX_MIN = 20'sh80000;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_VOICE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RENDER,
        ST_DRAIN,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } phase_ctrl_t;

    typedef struct packed {
        logic                       func;
        logic [ADDR_IN_W-1:0]       sample_address;
        logic signed [SMP_W-1:0]    sample_value;
        logic [ADDR_IN_W-1:0]       voice_offset;
        logic [ADDR_IN_W-1:0]       loop_begin;
        logic [ADDR_IN_W-1:0]       loop_finish;
        logic [STEP_W-1:0]          step_ratio;
        logic [FRAMES_W-1:0]        frames_left;
        logic                       last_voice;
    } in_item_t;

    typedef struct packed {
        logic signed [MIX_W-1:0]    mix_sample;
        logic [SLOT_W-1:0]          sample_slot;
        logic                       frame_last;
    } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/wvm_ram.sv -----
// ----------------------------------------------------------------------------
// wvm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/wvm_phase.sv -----
// ----------------------------------------------------------------------------
// wvm_phase
// Playback phase: 32.16 accumulate and loop wrap, one step a cycle on advance.
// ----------------------------------------------------------------------------
`default_nettype none

module wvm_phase (
    input  wire logic                              clk,
    input  wire wvm_pkg::phase_ctrl_t              ctrl,
    input  wire logic [wvm_pkg::ADDR_IN_W-1:0]     voice_offset,
    input  wire logic [wvm_pkg::ADDR_IN_W-1:0]     loop_begin,
    input  wire logic [wvm_pkg::ADDR_IN_W-1:0]     loop_finish,
    input  wire logic [wvm_pkg::STEP_W-1:0]        step_ratio,
    output logic      [wvm_pkg::PHASE_W-1:0]       offset
);

    logic [wvm_pkg::PHASE_W-1:0]  offset_reg, offset_next;
    logic [wvm_pkg::FRAC_W-1:0]   frac_reg, frac_next;
    logic [wvm_pkg::CARRY_W-1:0]  carry_reg, carry_next;
    logic [wvm_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [wvm_pkg::PHASE_W-1:0]  finish_reg, finish_next;
    logic [wvm_pkg::PHASE_W-1:0]  wrap_reg, wrap_next;

    logic [wvm_pkg::PHASE_W-1:0]  sum;
    logic [wvm_pkg::STEP_W:0]     acc;

    always_comb
    begin
        sum = offset_reg + wvm_pkg::PHASE_W'(carry_reg);
        acc = (wvm_pkg::STEP_W + 1)'(frac_reg) + (wvm_pkg::STEP_W + 1)'(step_reg);

        offset_next = offset_reg;
        frac_next   = frac_reg;
        carry_next  = carry_reg;
        step_next   = step_reg;
        finish_next = finish_reg;
        wrap_next   = wrap_reg;

        if (ctrl.load)
        begin
            offset_next = wvm_pkg::PHASE_W'(voice_offset);
            frac_next   = step_ratio[wvm_pkg::FRAC_W-1:0];
            carry_next  = wvm_pkg::CARRY_W'(step_ratio[wvm_pkg::STEP_W-1:wvm_pkg::FRAC_W]);
            step_next   = step_ratio;
            finish_next = wvm_pkg::PHASE_W'(loop_finish);
            wrap_next   = wvm_pkg::PHASE_W'(loop_finish) - wvm_pkg::PHASE_W'(loop_begin)
                          + wvm_pkg::PHASE_W'(1);
        end
        else if (ctrl.advance)
        begin
            offset_next = (sum >= finish_reg) ? (sum - wrap_reg) : sum;
            frac_next   = acc[wvm_pkg::FRAC_W-1:0];
            carry_next  = acc[wvm_pkg::STEP_W:wvm_pkg::FRAC_W];
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        frac_reg   <= frac_next;
        carry_reg  <= carry_next;
        step_reg   <= step_next;
        finish_reg <= finish_next;
        wrap_reg   <= wrap_next;
    end

    assign offset = offset_reg;

endmodule

`default_nettype wire

// ----- rtl/wavetable_voice_mixer_core.sv -----
// ----------------------------------------------------------------------------
// wavetable_voice_mixer_core
// Wavetable sample playback: loads sample words, mixes voices into a frame
// buffer and streams out the mixed frame.
// ----------------------------------------------------------------------------
// A load transaction (func 0) writes one sample word. An active voice makes
// one sample read and one mix buffer read-modify-write per frame slot not
// yet emitted, paced by the single phase unit that advances the playback
// offset once a cycle while rendering. An inactive voice, or one past
// MAX_VOICES in the frame, is not rendered. A last_voice transaction then
// emits up to 64 results, each loaded once result_ready is high or no
// result is held; item_ready stays low until the burst is loaded. After
// reset the mix buffer is cleared in one pass with item_ready low. Each slot
// is zeroed as it is emitted. SAMPLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_voice_mixer_core #(
    parameter int FRAME_LENGTH = 128,
    parameter int MAX_VOICES   = 16,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire wvm_pkg::in_item_t    item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output wvm_pkg::out_item_t        result
);

    localparam int IDX_W = (FRAME_LENGTH > 1) ? $clog2(FRAME_LENGTH) : 1;
    localparam int AW    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int VC_W  = $clog2(MAX_VOICES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LENGTH - 1);
    localparam logic [VC_W-1:0]  VOICE_MAX = VC_W'(MAX_VOICES);

    wvm_pkg::state_t              state_reg, state_next;
    logic [IDX_W-1:0]             step_idx_reg, step_idx_next;
    logic [IDX_W-1:0]             emit_idx_reg, emit_idx_next;
    logic [wvm_pkg::BURST_W-1:0]  burst_reg, burst_next;
    logic [VC_W-1:0]              voice_cnt_reg, voice_cnt_next;
    logic                         last_reg, last_next;
    logic                         wr_en_reg, wr_en_next;
    logic [IDX_W-1:0]             wr_idx_reg, wr_idx_next;
    logic                         result_valid_reg, result_valid_next;
    wvm_pkg::out_item_t           result_reg, result_next;

    logic                         voice_accept;
    logic                         load_accept;
    logic                         render_go;
    logic                         load_ok;
    logic                         emit_load;
    logic                         emit_end;
    wvm_pkg::phase_ctrl_t         phase_ctrl;
    logic [wvm_pkg::PHASE_W-1:0]  offset;

    logic                         smp_we;
    logic [AW-1:0]                smp_waddr;
    logic [AW-1:0]                smp_raddr;
    logic [wvm_pkg::SMP_W-1:0]    smp_rdata;
    logic [AW+wvm_pkg::ADDR_IN_W-1:0] load_addr_wide;

    logic                         mix_we;
    logic [IDX_W-1:0]             mix_waddr;
    logic [wvm_pkg::MIX_W-1:0]    mix_wdata;
    logic [IDX_W-1:0]             mix_raddr;
    logic [wvm_pkg::MIX_W-1:0]    mix_rdata;

    logic signed [wvm_pkg::SMP_W-1:0] smp_s;
    logic signed [wvm_pkg::MIX_W-1:0] mix_s;
    logic signed [wvm_pkg::MIX_W:0]   mix_sum;
    logic signed [wvm_pkg::MIX_W-1:0] mix_sat;
    logic [IDX_W+wvm_pkg::SLOT_W-1:0] slot_wide;

    assign voice_accept = item_valid && item_ready && (item.func == wvm_pkg::FUNC_VOICE);
    assign load_accept  = item_valid && item_ready && (item.func == wvm_pkg::FUNC_LOAD);
    assign render_go    = (voice_cnt_reg < VOICE_MAX) && (item.frames_left != '0);
    assign load_ok      = !result_valid_reg || result_ready;
    assign emit_load    = (state_reg == wvm_pkg::ST_EMIT_LOAD) && load_ok;
    assign emit_end     = (emit_idx_reg == LAST_IDX) || (burst_reg == wvm_pkg::BURST_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wvm_pkg::ST_CLEAR:
            begin
                if (step_idx_reg == LAST_IDX)
                begin
                    state_next = wvm_pkg::ST_IDLE;
                end
            end
            wvm_pkg::ST_IDLE:
            begin
                if (voice_accept)
                begin
                    if (render_go)
                    begin
                        state_next = wvm_pkg::ST_RENDER;
                    end
                    else if (item.last_voice)
                    begin
                        state_next = wvm_pkg::ST_EMIT_READ;
                    end
                end
            end
            wvm_pkg::ST_RENDER:
            begin
                if (step_idx_reg == LAST_IDX)
                begin
                    state_next = wvm_pkg::ST_DRAIN;
                end
            end
            wvm_pkg::ST_DRAIN:
            begin
                state_next = last_reg ? wvm_pkg::ST_EMIT_READ : wvm_pkg::ST_IDLE;
            end
            wvm_pkg::ST_EMIT_READ:
            begin
                state_next = wvm_pkg::ST_EMIT_LOAD;
            end
            wvm_pkg::ST_EMIT_LOAD:
            begin
                if (load_ok)
                begin
                    state_next = emit_end ? wvm_pkg::ST_IDLE : wvm_pkg::ST_EMIT_READ;
                end
            end
            default:
            begin
                state_next = wvm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        item_ready         = (state_reg == wvm_pkg::ST_IDLE);
        phase_ctrl.load    = voice_accept;
        phase_ctrl.advance = (state_reg == wvm_pkg::ST_RENDER);

        mix_raddr = step_idx_reg;
        case (state_reg)
            wvm_pkg::ST_EMIT_READ, wvm_pkg::ST_EMIT_LOAD:
            begin
                mix_raddr = emit_idx_reg;
            end
            default:
            begin
                mix_raddr = step_idx_reg;
            end
        endcase

        mix_we    = 1'b0;
        mix_waddr = step_idx_reg;
        mix_wdata = '0;
        if (state_reg == wvm_pkg::ST_CLEAR)
        begin
            mix_we = 1'b1;
        end
        else if (wr_en_reg)
        begin
            mix_we    = 1'b1;
            mix_waddr = wr_idx_reg;
            mix_wdata = mix_sat;
        end
        else if (emit_load)
        begin
            mix_we    = 1'b1;
            mix_waddr = emit_idx_reg;
        end
    end

    // counters and result register
    always_comb
    begin
        step_idx_next     = step_idx_reg;
        emit_idx_next     = emit_idx_reg;
        burst_next        = burst_reg;
        voice_cnt_next    = voice_cnt_reg;
        last_next         = last_reg;
        wr_en_next        = 1'b0;
        wr_idx_next       = step_idx_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if ((state_reg == wvm_pkg::ST_CLEAR) || (state_reg == wvm_pkg::ST_RENDER))
        begin
            step_idx_next = step_idx_reg + IDX_W'(1);
        end

        if (state_reg == wvm_pkg::ST_RENDER)
        begin
            wr_en_next = (step_idx_reg >= emit_idx_reg);
        end

        if ((state_reg == wvm_pkg::ST_IDLE) || (state_reg == wvm_pkg::ST_DRAIN))
        begin
            burst_next = '0;
        end

        if (voice_accept)
        begin
            step_idx_next = '0;
            last_next     = item.last_voice;
            if (voice_cnt_reg < VOICE_MAX)
            begin
                voice_cnt_next = voice_cnt_reg + VC_W'(1);
            end
        end

        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end

        if (emit_load)
        begin
            result_valid_next      = 1'b1;
            result_next.mix_sample = mix_s;
            result_next.sample_slot = slot_wide[wvm_pkg::SLOT_W-1:0];
            result_next.frame_last = (emit_idx_reg == LAST_IDX);
            burst_next             = burst_reg + wvm_pkg::BURST_W'(1);
            if (emit_idx_reg == LAST_IDX)
            begin
                emit_idx_next  = '0;
                voice_cnt_next = '0;
            end
            else
            begin
                emit_idx_next = emit_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= wvm_pkg::ST_CLEAR;
            step_idx_reg     <= '0;
            emit_idx_reg     <= '0;
            burst_reg        <= '0;
            voice_cnt_reg    <= '0;
            last_reg         <= 1'b0;
            wr_en_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_idx_reg     <= step_idx_next;
            emit_idx_reg     <= emit_idx_next;
            burst_reg        <= burst_next;
            voice_cnt_reg    <= voice_cnt_next;
            last_reg         <= last_next;
            wr_en_reg        <= wr_en_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg <= wr_idx_next;
        result_reg <= result_next;
    end

    // saturate the mix sum
    always_comb
    begin
        smp_s     = smp_rdata;
        mix_s     = mix_rdata;
        mix_sum   = (wvm_pkg::MIX_W + 1)'(mix_s) + (wvm_pkg::MIX_W + 1)'(smp_s);
        slot_wide = (IDX_W + wvm_pkg::SLOT_W)'(emit_idx_reg);
        if (mix_sum[wvm_pkg::MIX_W] != mix_sum[wvm_pkg::MIX_W-1])
        begin
            mix_sat = mix_sum[wvm_pkg::MIX_W] ? wvm_pkg::MIX_MIN : wvm_pkg::MIX_MAX;
        end
        else
        begin
            mix_sat = mix_sum[wvm_pkg::MIX_W-1:0];
        end
    end

    assign load_addr_wide = (AW + wvm_pkg::ADDR_IN_W)'(item.sample_address);
    assign smp_we         = load_accept;
    assign smp_waddr      = load_addr_wide[AW-1:0];
    assign smp_raddr      = offset[AW-1:0];

    wvm_phase u_phase (
        .clk          (clk),
        .ctrl         (phase_ctrl),
        .voice_offset (item.voice_offset),
        .loop_begin   (item.loop_begin),
        .loop_finish  (item.loop_finish),
        .step_ratio   (item.step_ratio),
        .offset       (offset)
    );

    wvm_ram #(
        .WIDTH (wvm_pkg::SMP_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (item.sample_value),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    wvm_ram #(
        .WIDTH (wvm_pkg::MIX_W),
        .DEPTH (FRAME_LENGTH)
    ) u_mix_ram (
        .clk   (clk),
        .we    (mix_we),
        .waddr (mix_waddr),
        .wdata (mix_wdata),
        .raddr (mix_raddr),
        .rdata (mix_rdata)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_no_write_to_emitted: assert property (
        @(posedge clk) disable iff (!rst_n)
        wr_en_reg |-> (wr_idx_reg >= emit_idx_reg))
        else $error("render write into an emitted slot");

    a_frame_end_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (emit_load && (emit_idx_reg == LAST_IDX))
            |=> (voice_cnt_reg == '0) && (emit_idx_reg == '0))
        else $error("frame end did not clear counters");

    a_voice_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        voice_cnt_reg <= VOICE_MAX)
        else $error("voice count beyond limit");

    a_idle_no_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_ready |-> !wr_en_reg)
        else $error("pending mix write while ready");

endmodule

`default_nettype wire
